### design/kmc_pkg.sv
`timescale 1ns / 1ps
package kmc_pkg;

    localparam int MAX_POINTS     = 1024;
    localparam int MAX_CLUSTERS   = 8;
    localparam int COORD_WIDTH    = 16;
    localparam int PT_AW          = $clog2(MAX_POINTS);
    localparam int CL_AW          = $clog2(MAX_CLUSTERS);
    localparam int CNT_W          = PT_AW + 1;
    localparam int CLN_W          = CL_AW + 1;
    localparam int SUM_W          = COORD_WIDTH + PT_AW;
    localparam int DIFF_W         = COORD_WIDTH + 1;
    localparam int SQ_W           = 2 * DIFF_W;
    localparam int DIST_W         = SQ_W + 1;
    localparam int ITER_W         = 8;
    localparam int DIV_CNT_W      = $clog2(SUM_W + 1);
    localparam int APB_AW         = 4;
    localparam logic [ITER_W-1:0] DEFAULT_ITER = ITER_W'(100);

    typedef enum logic [2:0] {
        ACT_WR_POINT = 3'd0,
        ACT_WR_CENT  = 3'd1,
        ACT_RUN      = 3'd2,
        ACT_RD_LABEL = 3'd3,
        ACT_RD_CENT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_POINT_COUNT   = 2'd0,
        REG_NUM_CLUSTERS  = 2'd1,
        REG_ITER_COUNT    = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP,
        S_RUN_START,
        S_ROUND,
        S_PREAD,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_WLAB,
        S_UPD,
        S_DIVX,
        S_DIVY,
        S_ITER
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic run_init;
        logic round_init;
        logic pt_read;
        logic diff;
        logic mul;
        logic cmp;
        logic wlab;
        logic upd_init;
        logic cl_inc;
        logic div_start_x;
        logic div_start_y;
        logic div_wr_x;
        logic div_wr_y;
        logic iter_dec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic          in_fire;
        logic [2:0]    in_action;
        logic          clr_last;
        logic          pt_end;
        logic          cl_last;
        logic          cl_end;
        logic          cnt_zero;
        logic          iter_zero;
        logic          iter_one;
        logic          div_busy;
        logic          out_free;
    } sts_t;

endpackage

### design/kmc_in_if.sv
`timescale 1ns / 1ps
interface kmc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [9:0]  item_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;

    modport source (output valid, action, item_index, coord_x, coord_y, input ready);
    modport sink   (input valid, action, item_index, coord_x, coord_y, output ready);
endinterface

### design/kmc_out_if.sv
`timescale 1ns / 1ps
interface kmc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  label;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [10:0] member_count;
    logic        run_done;

    modport source (output valid, label, centre_x, centre_y, member_count, run_done,
                    input ready);
    modport sink   (input valid, label, centre_x, centre_y, member_count, run_done,
                    output ready);
endinterface

### design/kmeans_clustering_2d_core.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake        Payload
// item_in     in   valid/ready      action, item_index, coord_x, coord_y
// result_out  out  valid/ready      label, centre_x, centre_y, member_count, run_done
// apb         in   psel/penable     paddr, pwdata, pwrite -> prdata, pready
//
// After reset a pass over every entry clears the label memory; no request is taken meanwhile.
// Writes are done in idle as the request is taken; reads go through the response step, which waits for the result slot.
// A run does the given number of iterations; each reads every point, finds its nearest
// centroid by a difference, multiply and compare step per centroid, writes its label,
// then runs the shared 26-step divider once per coordinate of each non-empty cluster.
// Requests are taken only in idle; a stalled result holds the block in its response step.
module kmeans_clustering_2d_core
    import kmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    kmc_in_if.sink             item_in,
    kmc_out_if.source          result_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CNT_W-1:0]  point_count_reg;
    logic [3:0]        num_clusters_reg;
    logic [ITER_W-1:0] iteration_count_reg;
    logic              cfg_wr;
    reg_idx_t          reg_sel;
    cmd_t              cmd;
    sts_t              sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg     <= '0;
            num_clusters_reg    <= 4'd1;
            iteration_count_reg <= DEFAULT_ITER;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_POINT_COUNT:   point_count_reg     <= pwdata[CNT_W-1:0];
                REG_NUM_CLUSTERS:  num_clusters_reg    <= pwdata[3:0];
                REG_ITER_COUNT:    iteration_count_reg <= pwdata[ITER_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_POINT_COUNT:   prdata = 32'(point_count_reg);
            REG_NUM_CLUSTERS:  prdata = 32'(num_clusters_reg);
            REG_ITER_COUNT:    prdata = 32'(iteration_count_reg);
            default:           prdata = '0;
        endcase
    end

    kmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    kmc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .point_count     (point_count_reg),
        .num_clusters    (num_clusters_reg),
        .iteration_count (iteration_count_reg),
        .item_in         (item_in),
        .result_out      (result_out)
    );

endmodule

### design/kmc_div.sv
`timescale 1ns / 1ps
module kmc_div
    import kmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    busy,
    output logic [COORD_WIDTH-1:0]  quotient
);

    logic [SUM_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 busy_reg, busy_next;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_sub;
    logic [SUM_W-1:0]     q_signed;

    assign rem_sh  = {rem_reg, q_reg[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[CNT_W])
            begin
                rem_next = rem_sub[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign q_signed = neg_reg ? (~q_reg + SUM_W'(1)) : q_reg;
    assign quotient = q_signed[COORD_WIDTH-1:0];
    assign busy     = busy_reg;

endmodule

### design/kmc_ctrl.sv
`timescale 1ns / 1ps
module kmc_ctrl
    import kmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sts.in_fire)
                begin
                    if (sts.in_action == ACT_RUN)
                    begin
                        state_next = S_RUN_START;
                    end
                    else if (sts.in_action == ACT_RD_LABEL || sts.in_action == ACT_RD_CENT)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN_START: state_next = sts.iter_zero ? S_RESP : S_ROUND;
            S_ROUND:     state_next = S_PREAD;
            S_PREAD:     state_next = sts.pt_end ? S_UPD : S_DIFF;
            S_DIFF:      state_next = S_MUL;
            S_MUL:       state_next = S_CMP;
            S_CMP:       state_next = sts.cl_last ? S_WLAB : S_DIFF;
            S_WLAB:      state_next = S_PREAD;
            S_UPD:
            begin
                if (sts.cl_end)
                begin
                    state_next = S_ITER;
                end
                else if (!sts.cnt_zero)
                begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_UPD;
                end
            end
            S_ITER:      state_next = sts.iter_one ? S_RESP : S_ROUND;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:     cmd.clr_step = 1'b1;
            S_IDLE:      cmd.take = 1'b1;
            S_RESP:      cmd.load_out = sts.out_free;
            S_RUN_START: cmd.run_init = 1'b1;
            S_ROUND:     cmd.round_init = 1'b1;
            S_PREAD:
            begin
                cmd.pt_read  = !sts.pt_end;
                cmd.upd_init = sts.pt_end;
            end
            S_DIFF:      cmd.diff = 1'b1;
            S_MUL:       cmd.mul = 1'b1;
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                cmd.cl_inc = !sts.cl_last;
            end
            S_WLAB:      cmd.wlab = 1'b1;
            S_UPD:
            begin
                cmd.cl_inc      = !sts.cl_end && sts.cnt_zero;
                cmd.div_start_x = !sts.cl_end && !sts.cnt_zero;
            end
            S_DIVX:
            begin
                cmd.div_wr_x    = !sts.div_busy;
                cmd.div_start_y = !sts.div_busy;
            end
            S_DIVY:
            begin
                cmd.div_wr_y = !sts.div_busy;
                cmd.cl_inc   = !sts.div_busy;
            end
            S_ITER:      cmd.iter_dec = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

### design/kmc_dp.sv
`timescale 1ns / 1ps
module kmc_dp
    import kmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [CNT_W-1:0]      point_count,
    input  logic [3:0]            num_clusters,
    input  logic [ITER_W-1:0]     iteration_count,
    kmc_in_if.sink                item_in,
    kmc_out_if.source             result_out
);

    logic [COORD_WIDTH-1:0] px_mem [MAX_POINTS];
    logic [COORD_WIDTH-1:0] py_mem [MAX_POINTS];
    logic [CL_AW-1:0]       lab_mem [MAX_POINTS];

    logic signed [COORD_WIDTH-1:0] cx_reg [MAX_CLUSTERS];
    logic signed [COORD_WIDTH-1:0] cy_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]       sx_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]       sy_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]              mc_reg [MAX_CLUSTERS];

    logic signed [COORD_WIDTH-1:0] px_rd_reg, py_rd_reg;
    logic [CL_AW-1:0]  lab_rd_reg;
    logic [2:0]        act_reg;
    logic [PT_AW-1:0]  idx_reg;
    logic [CNT_W-1:0]  clr_reg, pt_reg, n_reg;
    logic [CLN_W-1:0]  cl_reg, k_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [DIST_W-1:0] best_reg;
    logic [CL_AW-1:0]  pick_reg;

    logic              out_valid_reg;
    logic [CL_AW-1:0]  out_label_reg;
    logic [COORD_WIDTH-1:0] out_cx_reg, out_cy_reg;
    logic [CNT_W-1:0]  out_mc_reg;
    logic              out_done_reg;

    logic              in_fire;
    logic              lab_we;
    logic [PT_AW-1:0]  lab_waddr;
    logic [CL_AW-1:0]  lab_wdata;
    logic [CL_AW-1:0]  cl_idx;
    logic [CL_AW-1:0]  item_cl;
    logic              item_cl_ok;
    logic              idx_cl_ok;
    logic signed [DIFF_W-1:0] dxs, dys;
    logic [DIST_W-1:0] dsq;
    logic              div_start;
    logic              div_busy;
    logic [COORD_WIDTH-1:0] div_q;
    logic signed [SUM_W-1:0] div_num;

    assign in_fire    = item_in.valid & cmd.take;
    assign item_in.ready = cmd.take;
    assign cl_idx     = cl_reg[CL_AW-1:0];
    assign item_cl    = item_in.item_index[CL_AW-1:0];
    assign item_cl_ok = (item_in.item_index >> CL_AW) == '0;
    assign idx_cl_ok  = (idx_reg >> CL_AW) == '0;

    // point store
    always_ff @(posedge clk)
    begin
        if (in_fire && item_in.action == ACT_WR_POINT)
        begin
            px_mem[item_in.item_index] <= item_in.coord_x;
            py_mem[item_in.item_index] <= item_in.coord_y;
        end
        if (cmd.pt_read)
        begin
            px_rd_reg <= px_mem[pt_reg[PT_AW-1:0]];
            py_rd_reg <= py_mem[pt_reg[PT_AW-1:0]];
        end
    end

    // label store
    assign lab_we    = cmd.clr_step | cmd.wlab;
    assign lab_waddr = cmd.clr_step ? clr_reg[PT_AW-1:0] : pt_reg[PT_AW-1:0];
    assign lab_wdata = cmd.clr_step ? '0 : pick_reg;

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_waddr] <= lab_wdata;
        end
        if (in_fire)
        begin
            lab_rd_reg <= lab_mem[item_in.item_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= item_in.action;
            idx_reg <= item_in.item_index;
        end
    end

    // centroids
    always_ff @(posedge clk)
    begin
        if (in_fire && item_in.action == ACT_WR_CENT && item_cl_ok)
        begin
            cx_reg[item_cl] <= item_in.coord_x;
            cy_reg[item_cl] <= item_in.coord_y;
        end
        if (cmd.div_wr_x)
        begin
            cx_reg[cl_idx] <= div_q;
        end
        if (cmd.div_wr_y)
        begin
            cy_reg[cl_idx] <= div_q;
        end
    end

    // sums and member counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_CLUSTERS; j++)
            begin
                sx_reg[j] <= '0;
                sy_reg[j] <= '0;
                mc_reg[j] <= '0;
            end
        end
        else if (cmd.round_init)
        begin
            for (int j = 0; j < MAX_CLUSTERS; j++)
            begin
                sx_reg[j] <= '0;
                sy_reg[j] <= '0;
                mc_reg[j] <= '0;
            end
        end
        else if (cmd.wlab)
        begin
            sx_reg[pick_reg] <= sx_reg[pick_reg] + SUM_W'(px_rd_reg);
            sy_reg[pick_reg] <= sy_reg[pick_reg] + SUM_W'(py_rd_reg);
            mc_reg[pick_reg] <= mc_reg[pick_reg] + CNT_W'(1);
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            pt_reg   <= '0;
            cl_reg   <= '0;
            n_reg    <= '0;
            k_reg    <= CLN_W'(1);
            iter_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CNT_W'(1);
            end
            if (cmd.run_init)
            begin
                n_reg    <= (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                               : point_count;
                k_reg    <= (num_clusters == '0) ? CLN_W'(1) :
                            (num_clusters > 4'(MAX_CLUSTERS)) ? CLN_W'(MAX_CLUSTERS) :
                            CLN_W'(num_clusters);
                iter_reg <= iteration_count;
            end
            if (cmd.round_init)
            begin
                pt_reg <= '0;
            end
            else if (cmd.wlab)
            begin
                pt_reg <= pt_reg + CNT_W'(1);
            end
            if (cmd.pt_read || cmd.upd_init)
            begin
                cl_reg <= '0;
            end
            else if (cmd.cl_inc)
            begin
                cl_reg <= cl_reg + CLN_W'(1);
            end
            if (cmd.iter_dec)
            begin
                iter_reg <= iter_reg - ITER_W'(1);
            end
        end
    end

    // distance path
    assign dxs  = DIFF_W'(px_rd_reg) - DIFF_W'(cx_reg[cl_idx]);
    assign dys  = DIFF_W'(py_rd_reg) - DIFF_W'(cy_reg[cl_idx]);
    assign dsq  = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
            dy_reg <= dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
        end
        if (cmd.mul)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
        if (cmd.cmp && (cl_reg == '0 || dsq < best_reg))
        begin
            best_reg <= dsq;
            pick_reg <= cl_idx;
        end
    end

    // mean
    assign div_start = cmd.div_start_x | cmd.div_start_y;
    assign div_num   = cmd.div_start_y ? sy_reg[cl_idx] : sx_reg[cl_idx];

    kmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (mc_reg[cl_idx]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_label_reg <= '0;
            out_cx_reg    <= '0;
            out_cy_reg    <= '0;
            out_mc_reg    <= '0;
            out_done_reg  <= (act_reg == ACT_RUN);
            if (act_reg == ACT_RD_LABEL)
            begin
                out_label_reg <= lab_rd_reg;
            end
            else if (act_reg == ACT_RD_CENT && idx_cl_ok)
            begin
                out_label_reg <= idx_reg[CL_AW-1:0];
                out_cx_reg    <= cx_reg[idx_reg[CL_AW-1:0]];
                out_cy_reg    <= cy_reg[idx_reg[CL_AW-1:0]];
                out_mc_reg    <= mc_reg[idx_reg[CL_AW-1:0]];
            end
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.label        = out_label_reg;
    assign result_out.centre_x     = out_cx_reg;
    assign result_out.centre_y     = out_cy_reg;
    assign result_out.member_count = out_mc_reg;
    assign result_out.run_done     = out_done_reg;

    always_comb
    begin
        sts.in_fire   = in_fire;
        sts.in_action = item_in.action;
        sts.clr_last  = clr_reg == CNT_W'(MAX_POINTS - 1);
        sts.pt_end    = pt_reg == n_reg;
        sts.cl_last   = cl_reg == (k_reg - CLN_W'(1));
        sts.cl_end    = cl_reg == k_reg;
        sts.cnt_zero  = mc_reg[cl_idx] == '0;
        sts.iter_zero = iteration_count == '0;
        sts.iter_one  = iter_reg == ITER_W'(1);
        sts.div_busy  = div_busy;
        sts.out_free  = !out_valid_reg || result_out.ready;
    end

endmodule
